/* rtl/core/bdhl_pkg.sv */
// ----------------------------------------------------------------------------
// Button qualifier package
// Phase encoding, event codes and register indexes shared by the button
// debounce and hold-level qualifier.
// ----------------------------------------------------------------------------
package bdhl_pkg;

   // Width of each configuration register and of the write data bus.
   localparam int unsigned CSR_WIDTH     = 16;
   localparam int unsigned CSR_IDX_WIDTH = 3;
   localparam int unsigned CODE_WIDTH    = 3;

   // Configuration register indexes.
   localparam logic [CSR_IDX_WIDTH-1:0] CSR_DEBOUNCE    = 3'd0;
   localparam logic [CSR_IDX_WIDTH-1:0] CSR_HELD        = 3'd1;
   localparam logic [CSR_IDX_WIDTH-1:0] CSR_FIRST_HOLD  = 3'd2;
   localparam logic [CSR_IDX_WIDTH-1:0] CSR_SECOND_HOLD = 3'd3;
   localparam logic [CSR_IDX_WIDTH-1:0] CSR_THIRD_HOLD  = 3'd4;

   // Register values after reset.
   localparam logic [CSR_WIDTH-1:0] DEBOUNCE_RESET    = 16'd1;
   localparam logic [CSR_WIDTH-1:0] HELD_RESET        = 16'd7;
   localparam logic [CSR_WIDTH-1:0] FIRST_HOLD_RESET  = 16'd16;
   localparam logic [CSR_WIDTH-1:0] SECOND_HOLD_RESET = 16'd32;
   localparam logic [CSR_WIDTH-1:0] THIRD_HOLD_RESET  = 16'd48;

   // Event codes reported on the result channel.
   localparam logic [CODE_WIDTH-1:0] EV_NONE   = 3'd0;
   localparam logic [CODE_WIDTH-1:0] EV_PRESS  = 3'd1;
   localparam logic [CODE_WIDTH-1:0] EV_HELD   = 3'd2;
   localparam logic [CODE_WIDTH-1:0] EV_FIRST  = 3'd3;
   localparam logic [CODE_WIDTH-1:0] EV_SECOND = 3'd4;
   localparam logic [CODE_WIDTH-1:0] EV_THIRD  = 3'd5;

   // Phase codes reported on the result channel.
   localparam logic [CODE_WIDTH-1:0] PH_CODE_IDLE     = 3'd0;
   localparam logic [CODE_WIDTH-1:0] PH_CODE_PRESSED  = 3'd1;
   localparam logic [CODE_WIDTH-1:0] PH_CODE_RELEASED = 3'd2;
   localparam logic [CODE_WIDTH-1:0] PH_CODE_HELD     = 3'd3;
   localparam logic [CODE_WIDTH-1:0] PH_CODE_FIRST    = 3'd4;
   localparam logic [CODE_WIDTH-1:0] PH_CODE_SECOND   = 3'd5;
   localparam logic [CODE_WIDTH-1:0] PH_CODE_THIRD    = 3'd6;

   // One-hot phase machine encoding.
   typedef enum logic [6:0] {
      PH_IDLE     = 7'b000_0001,
      PH_PRESSED  = 7'b000_0010,
      PH_RELEASED = 7'b000_0100,
      PH_HELD     = 7'b000_1000,
      PH_FIRST    = 7'b001_0000,
      PH_SECOND   = 7'b010_0000,
      PH_THIRD    = 7'b100_0000
   } phase_type;

   // Maps the one-hot phase onto the code shown on the result channel.
   function automatic logic [CODE_WIDTH-1:0] phase_code(input phase_type ph);
      logic [CODE_WIDTH-1:0] code;
      unique case (ph)
         PH_PRESSED:  code = PH_CODE_PRESSED;
         PH_RELEASED: code = PH_CODE_RELEASED;
         PH_HELD:     code = PH_CODE_HELD;
         PH_FIRST:    code = PH_CODE_FIRST;
         PH_SECOND:   code = PH_CODE_SECOND;
         PH_THIRD:    code = PH_CODE_THIRD;
         default:     code = PH_CODE_IDLE;
      endcase
      return code;
   endfunction

endpackage

/* rtl/core/button_debounce_hold_levels_top.sv */
// ----------------------------------------------------------------------------
// Button debounce and hold-level qualifier
// Qualifies one push button from a stream of polls (pin level plus a
// free-running tick value) and reports press, held and three hold-level
// events together with the current phase.
// ----------------------------------------------------------------------------
//
//   Channel  Direction  Handshake              Payload
//   req      in         req_valid / req_stall  req_button_level, req_now_tick
//   rsp      out        rsp_valid / rsp_stall  rsp_event_res, rsp_phase
//   csr      in         csr_write_en           csr_index, csr_wdata
//
// Each poll transaction gives exactly one result transaction. A transaction
// is first captured in an input register; from there the phase machine is
// evaluated and the result lands in the result register. One transaction
// can be taken every cycle while rsp_stall is low.
// The two registers form a skid pair: while the result register is held by
// rsp_stall, one further transaction is still accepted into the input
// register, and only then does req_stall rise.
// Reset is synchronous and active high; it returns the phase machine to
// idle, empties both registers and restores the register defaults.
//
// All tick differences are taken modulo 2^TICK_WIDTH. A threshold that is
// larger than the largest possible difference therefore never fires.
// ----------------------------------------------------------------------------
module button_debounce_hold_levels_top
   import bdhl_pkg::*;
#(
   parameter int unsigned TICK_WIDTH = 16
) (
   input  logic                     clock,
   input  logic                     reset,

   // Poll transactions.
   input  logic                     req_valid,
   output logic                     req_stall,
   input  logic                     req_button_level,
   input  logic [TICK_WIDTH-1:0]    req_now_tick,

   // Result transactions.
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output logic [CODE_WIDTH-1:0]    rsp_event_res,
   output logic [CODE_WIDTH-1:0]    rsp_phase,

   // Configuration writes.
   input  logic                     csr_write_en,
   input  logic [CSR_IDX_WIDTH-1:0] csr_index,
   input  logic [CSR_WIDTH-1:0]     csr_wdata
);

   // Comparisons are made at the wider of the tick and register widths, so
   // that a threshold beyond the tick range can never be reached.
   localparam int unsigned CMP_WIDTH = (TICK_WIDTH > CSR_WIDTH) ? TICK_WIDTH : CSR_WIDTH;

   // Configuration registers.
   logic [CSR_WIDTH-1:0]  debounce_ff;
   logic [CSR_WIDTH-1:0]  held_ff;
   logic [CSR_WIDTH-1:0]  first_hold_ff;
   logic [CSR_WIDTH-1:0]  second_hold_ff;
   logic [CSR_WIDTH-1:0]  third_hold_ff;

   // Input register.
   logic                  req_hold_valid_ff;
   logic                  req_hold_valid_in;
   logic                  req_level_ff;
   logic [TICK_WIDTH-1:0] req_tick_ff;

   // Phase machine state.
   phase_type             phase_ff;
   phase_type             phase_in;
   logic [TICK_WIDTH-1:0] press_start_ff;
   logic [TICK_WIDTH-1:0] press_start_in;
   logic [TICK_WIDTH-1:0] hold_start_ff;
   logic [TICK_WIDTH-1:0] hold_start_in;

   // Result register.
   logic                  rsp_valid_ff;
   logic                  rsp_valid_in;
   logic [CODE_WIDTH-1:0] rsp_event_ff;
   logic [CODE_WIDTH-1:0] event_in;
   logic [CODE_WIDTH-1:0] rsp_phase_ff;

   // Control.
   logic                  advance;
   logic                  req_take;

   // Elapsed times and threshold checks.
   logic [TICK_WIDTH-1:0] press_elapsed;
   logic [TICK_WIDTH-1:0] hold_elapsed;
   logic                  reach_debounce;
   logic                  reach_held;
   logic                  reach_first;
   logic                  reach_second;
   logic                  reach_third;

   // ------------------------------------------------------------------------
   // Handshake. The held poll moves on whenever the result register is empty
   // or is being emptied in this cycle; the input register then takes a new
   // poll if it is empty or moving on.
   // ------------------------------------------------------------------------
   assign advance           = req_hold_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign req_stall         = req_hold_valid_ff && !advance;
   assign req_take          = req_valid && !req_stall;
   assign req_hold_valid_in = req_take || (req_hold_valid_ff && !advance);
   assign rsp_valid_in      = advance || (rsp_valid_ff && rsp_stall);

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_event_res = rsp_event_ff;
   assign rsp_phase     = rsp_phase_ff;

   // ------------------------------------------------------------------------
   // Elapsed ticks since press start and hold start, wrapping at the tick
   // width, compared against the zero-extended thresholds.
   // ------------------------------------------------------------------------
   assign press_elapsed = req_tick_ff - press_start_ff;
   assign hold_elapsed  = req_tick_ff - hold_start_ff;

   assign reach_debounce = CMP_WIDTH'(press_elapsed) >= CMP_WIDTH'(debounce_ff);
   assign reach_held     = CMP_WIDTH'(press_elapsed) >= CMP_WIDTH'(held_ff);
   assign reach_first    = CMP_WIDTH'(hold_elapsed)  >= CMP_WIDTH'(first_hold_ff);
   assign reach_second   = CMP_WIDTH'(hold_elapsed)  >= CMP_WIDTH'(second_hold_ff);
   assign reach_third    = CMP_WIDTH'(hold_elapsed)  >= CMP_WIDTH'(third_hold_ff);

   // ------------------------------------------------------------------------
   // Phase machine. A release in any hold phase, or in the released phase,
   // goes back to idle. A release before the debounce time is dropped
   // without an event.
   // ------------------------------------------------------------------------
   always_comb begin
      phase_in       = phase_ff;
      press_start_in = press_start_ff;
      hold_start_in  = hold_start_ff;
      event_in       = EV_NONE;
      unique case (phase_ff)
         PH_PRESSED: begin
            if (req_level_ff) begin
               if (reach_held) begin
                  event_in      = EV_HELD;
                  phase_in      = PH_HELD;
                  hold_start_in = req_tick_ff;
               end
            end else if (reach_debounce) begin
               event_in = EV_PRESS;
               phase_in = PH_RELEASED;
            end else begin
               phase_in = PH_IDLE;
            end
         end
         PH_RELEASED: begin
            if (!req_level_ff) begin
               phase_in = PH_IDLE;
            end
         end
         PH_HELD: begin
            if (!req_level_ff) begin
               phase_in = PH_IDLE;
            end else if (reach_first) begin
               event_in = EV_FIRST;
               phase_in = PH_FIRST;
            end
         end
         PH_FIRST: begin
            if (!req_level_ff) begin
               phase_in = PH_IDLE;
            end else if (reach_second) begin
               event_in = EV_SECOND;
               phase_in = PH_SECOND;
            end
         end
         PH_SECOND: begin
            if (!req_level_ff) begin
               phase_in = PH_IDLE;
            end else if (reach_third) begin
               event_in = EV_THIRD;
               phase_in = PH_THIRD;
            end
         end
         PH_THIRD: begin
            if (!req_level_ff) begin
               phase_in = PH_IDLE;
            end
         end
         default: begin
            // Idle, and any code that cannot arise, waits for a press.
            if (req_level_ff) begin
               phase_in       = PH_PRESSED;
               press_start_in = req_tick_ff;
            end else begin
               phase_in = PH_IDLE;
            end
         end
      endcase
   end

   // ------------------------------------------------------------------------
   // Configuration registers. Writes to an index beyond the last register
   // are ignored.
   // ------------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         debounce_ff    <= DEBOUNCE_RESET;
         held_ff        <= HELD_RESET;
         first_hold_ff  <= FIRST_HOLD_RESET;
         second_hold_ff <= SECOND_HOLD_RESET;
         third_hold_ff  <= THIRD_HOLD_RESET;
      end else if (csr_write_en) begin
         unique case (csr_index)
            CSR_DEBOUNCE:    debounce_ff    <= csr_wdata;
            CSR_HELD:        held_ff        <= csr_wdata;
            CSR_FIRST_HOLD:  first_hold_ff  <= csr_wdata;
            CSR_SECOND_HOLD: second_hold_ff <= csr_wdata;
            CSR_THIRD_HOLD:  third_hold_ff  <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

   // ------------------------------------------------------------------------
   // Control state: valid flags and the phase machine.
   // ------------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         req_hold_valid_ff <= 1'b0;
         rsp_valid_ff      <= 1'b0;
         phase_ff          <= PH_IDLE;
         press_start_ff    <= '0;
         hold_start_ff     <= '0;
      end else begin
         req_hold_valid_ff <= req_hold_valid_in;
         rsp_valid_ff      <= rsp_valid_in;
         if (advance) begin
            phase_ff       <= phase_in;
            press_start_ff <= press_start_in;
            hold_start_ff  <= hold_start_in;
         end
      end
   end

   // ------------------------------------------------------------------------
   // Payload registers.
   // ------------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (req_take) begin
         req_level_ff <= req_button_level;
         req_tick_ff  <= req_now_tick;
      end
      if (advance) begin
         rsp_event_ff <= event_in;
         rsp_phase_ff <= phase_code(phase_in);
      end
   end

endmodule
